FILE: hdl/slhf_pkg.sv
package slhf_pkg;

   localparam int COORD_W = 12;
   localparam int MS_W    = 10;
   localparam int RATE_W  = 12;
   localparam int OUT_W   = 15;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RATE = 2'd2;
   localparam logic [RATE_W-1:0]    MAX_RATE_RESET = 12'd360;

   // cordic datapath: offsets prescaled by 2^8, angle in 2^-16 degree
   localparam int PRESCALE = 8;
   localparam int ACC_FRAC = 16;
   localparam int XY_W     = 24;
   localparam int Z_W      = 27;
   localparam int TAB_W    = 5;
   localparam int MS_DIV   = 1000;

   localparam logic signed [Z_W-1:0] Z_HALF_TURN = 27'sd11796480;
   localparam logic signed [Z_W-1:0] Z_FULL_TURN = 27'sd23592960;

   typedef struct packed {
      logic [COORD_W-1:0] target_x;
      logic [COORD_W-1:0] target_y;
      logic [MS_W-1:0]    elapsed_ms;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] heading;
      logic [OUT_W-1:0] bearing;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic cordic;
      logic round;
      logic mul;
      logic div;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic cordic_last;
      logic out_free;
   } sts_type;

   // atan(2^-i) in degrees times 2^16, rounded
   function automatic logic signed [Z_W-1:0] atan_step(input logic [TAB_W-1:0] idx);
      logic signed [Z_W-1:0] v;
      begin
         unique case (idx)
            5'd0:  v = 27'sd2949120;
            5'd1:  v = 27'sd1740967;
            5'd2:  v = 27'sd919879;
            5'd3:  v = 27'sd466945;
            5'd4:  v = 27'sd234379;
            5'd5:  v = 27'sd117305;
            5'd6:  v = 27'sd58666;
            5'd7:  v = 27'sd29335;
            5'd8:  v = 27'sd14668;
            5'd9:  v = 27'sd7334;
            5'd10: v = 27'sd3667;
            5'd11: v = 27'sd1833;
            5'd12: v = 27'sd917;
            5'd13: v = 27'sd458;
            5'd14: v = 27'sd229;
            5'd15: v = 27'sd115;
            5'd16: v = 27'sd57;
            5'd17: v = 27'sd29;
            5'd18: v = 27'sd14;
            5'd19: v = 27'sd7;
            5'd20: v = 27'sd4;
            5'd21: v = 27'sd2;
            5'd22: v = 27'sd1;
            default: v = 27'sd0;
         endcase
         return v;
      end
   endfunction

endpackage

FILE: hdl/slhf_ctrl.sv
module slhf_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  slhf_pkg::sts_type sts,
   output slhf_pkg::cmd_type cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CORDIC = 6'b000010,
      ST_ROUND  = 6'b000100,
      ST_MUL    = 6'b001000,
      ST_DIV    = 6'b010000,
      ST_COMMIT = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in = ST_CORDIC;
            end
         end
         ST_CORDIC: begin
            cmd.cordic = 1'b1;
            if (sts.cordic_last) state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div = 1'b1;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            // wait until the output register can take the word
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   a_div_to_commit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |=> (state_ff == ST_COMMIT))
      else $error("division did not hand over to commit");
   a_start_to_cordic: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> (state_ff == ST_CORDIC))
      else $error("accepted word did not start cordic");
   a_cordic_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CORDIC && !sts.cordic_last) |=> (state_ff == ST_CORDIC))
      else $error("cordic left early");

endmodule

FILE: hdl/slhf_dp.sv
module slhf_dp #(
   parameter int ANGLE_FRAC_BITS = 6,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [slhf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [slhf_pkg::COORD_W-1:0]         csr_wdata,
   input  slhf_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   output slhf_pkg::rsp_type                    rsp_data,
   input  logic                                 rsp_stall,
   input  slhf_pkg::cmd_type                    cmd,
   output slhf_pkg::sts_type                    sts
);

   localparam int F     = ANGLE_FRAC_BITS;
   localparam int FULL  = 360 << F;
   localparam int AW    = $clog2(FULL);
   localparam int SW    = AW + 2;
   localparam int NW    = AW + 3;
   localparam int PW_S  = AW + slhf_pkg::MS_W;
   localparam int PW_C  = slhf_pkg::RATE_W + slhf_pkg::MS_W + F;
   localparam int DW    = (PW_S > PW_C) ? PW_S : PW_C;
   localparam int CW    = slhf_pkg::TAB_W;
   localparam int RSH   = slhf_pkg::ACC_FRAC - F;
   localparam int XW    = slhf_pkg::XY_W;
   localparam int ZW    = slhf_pkg::Z_W;
   // divide by 1000 as a shift by 3 and a multiply by the rounded-up
   // reciprocal of 125; exact for dividends below 2^DW
   localparam int QW    = DW - 3;
   localparam int RK    = QW + 7;
   localparam int ODD   = slhf_pkg::MS_DIV / 8;
   localparam logic [QW:0] RECIP = (QW+1)'(((64'd1 << RK) + 64'(ODD - 1)) / 64'(ODD));

   logic [slhf_pkg::COORD_W-1:0] cx_ff, cy_ff;
   logic [slhf_pkg::RATE_W-1:0]  rate_ff;
   logic signed [XW-1:0] x_ff, y_ff;
   logic signed [ZW-1:0] z_ff;
   logic                 zero_ff;
   logic [slhf_pkg::MS_W-1:0] ms_ff;
   logic [CW-1:0]        cnt_ff;
   logic [AW-1:0]        a_ff, p_ff;
   logic [DW-1:0]        dvs_ff, dvc_ff;
   logic                 rsp_valid_ff;
   slhf_pkg::rsp_type    rsp_ff;

   // config words
   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= '0;
         cy_ff <= '0;
         rate_ff <= slhf_pkg::MAX_RATE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            slhf_pkg::CSR_CENTER_X: cx_ff <= csr_wdata;
            slhf_pkg::CSR_CENTER_Y: cy_ff <= csr_wdata;
            slhf_pkg::CSR_MAX_RATE: rate_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // offsets and cordic start vector, folded into the right half plane
   logic signed [12:0] dx, dy;
   logic signed [XW-1:0] x0, y0;
   assign dx = $signed({1'b0, req_data.target_x}) - $signed({1'b0, cx_ff});
   assign dy = $signed({1'b0, req_data.target_y}) - $signed({1'b0, cy_ff});
   assign x0 = {{(XW-13-slhf_pkg::PRESCALE){dx[12]}}, dx, {slhf_pkg::PRESCALE{1'b0}}};
   assign y0 = {{(XW-13-slhf_pkg::PRESCALE){dy[12]}}, dy, {slhf_pkg::PRESCALE{1'b0}}};

   logic [slhf_pkg::TAB_W-1:0] idx;
   logic signed [XW-1:0] xs, ys;
   logic signed [ZW-1:0] at;
   assign idx = cnt_ff;
   assign xs = x_ff >>> idx;
   assign ys = y_ff >>> idx;
   assign at = slhf_pkg::atan_step(idx);

   // bearing rounding
   logic signed [ZW-1:0] zm, zr;
   logic [AW:0] rr;
   logic [AW-1:0] a_new;
   assign zm = (z_ff < 0) ? z_ff + slhf_pkg::Z_FULL_TURN : z_ff;
   assign zr = (zm + (ZW'(1) <<< (RSH - 1))) >>> RSH;
   assign rr = zr[AW:0];
   always_comb begin
      if (zero_ff) a_new = '0;
      else if (rr >= (AW+1)'(FULL)) a_new = AW'(rr - (AW+1)'(FULL));
      else a_new = rr[AW-1:0];
   end

   // step and cap products
   logic [AW-1:0] diff;
   logic [PW_S-1:0] ps;
   logic [PW_C-1:0] pc;
   assign diff = (a_ff > p_ff) ? a_ff - p_ff : p_ff - a_ff;
   assign ps = diff * ms_ff;
   assign pc = (PW_C'(rate_ff) * PW_C'(ms_ff)) << F;

   // quotients by 1000
   logic [2*QW:0] qs, qc;
   assign qs = dvs_ff[DW-1:3] * RECIP;
   assign qc = dvc_ff[DW-1:3] * RECIP;

   // heading update
   logic [DW-1:0] dmin;
   logic signed [NW-1:0] delta, a_s, p_s, c_lo, c_hi, pn, w1, w2;
   logic [AW-F:0] aq;
   always_comb begin
      dmin = (dvs_ff < dvc_ff) ? dvs_ff : dvc_ff;
      delta = $signed({2'b0, dmin[AW:0]});
      a_s = $signed({3'b0, a_ff});
      p_s = $signed({3'b0, p_ff});
      aq = (AW-F+1)'(a_ff >> F) + (AW-F+1)'(|a_ff[F-1:0]);
      c_lo = ($signed({{(NW-AW+F-1){1'b0}}, aq}) - NW'(180)) <<< F;
      c_hi = ($signed({{(NW-AW+F-1){1'b0}}, aq}) + NW'(180)) <<< F;
      pn = p_s;
      if (a_s > p_s) begin
         if (c_lo > p_s) pn = p_s - delta;
         else pn = p_s + delta;
      end else if (a_s < p_s) begin
         if (c_hi < p_s) pn = p_s + delta;
         else pn = p_s - delta;
      end
      // the step may overshoot past one turn, so wrap twice
      if (pn < 0) w1 = pn + NW'(FULL);
      else if (pn >= NW'(FULL)) w1 = pn - NW'(FULL);
      else w1 = pn;
      if (w1 < 0) w2 = w1 + NW'(FULL);
      else if (w1 >= NW'(FULL)) w2 = w1 - NW'(FULL);
      else w2 = w1;
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         zero_ff <= (dx == 0) && (dy == 0);
         ms_ff <= req_data.elapsed_ms;
         cnt_ff <= '0;
         if (dx < 0) begin
            x_ff <= -x0;
            y_ff <= -y0;
            z_ff <= slhf_pkg::Z_HALF_TURN;
         end else begin
            x_ff <= x0;
            y_ff <= y0;
            z_ff <= '0;
         end
      end else if (cmd.cordic) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (y_ff > 0) begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + at;
         end else begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - at;
         end
      end else if (cmd.round) begin
         a_ff <= a_new;
      end else if (cmd.mul) begin
         dvs_ff <= DW'(ps);
         dvc_ff <= DW'(pc);
      end else if (cmd.div) begin
         dvs_ff <= DW'(qs[2*QW:RK]);
         dvc_ff <= DW'(qc[2*QW:RK]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) p_ff <= '0;
      else if (cmd.commit) p_ff <= w2[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.commit) rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff.heading <= slhf_pkg::OUT_W'(w2[AW-1:0]);
         rsp_ff.bearing <= slhf_pkg::OUT_W'(a_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign sts.cordic_last = (cnt_ff == CW'(CORDIC_STEPS - 1));
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      p_ff < AW'(FULL))
      else $error("heading out of range");
   a_bearing_range: assert property (@(posedge clock) disable iff (reset)
      cmd.mul |-> (a_ff < AW'(FULL)))
      else $error("bearing out of range");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_valid_ff && rsp_stall))
      else $error("result word overwritten while stalled");

endmodule

FILE: hdl/slew_limited_heading_follower.sv
// heading follower: turns a stored heading toward the bearing of a target point
//
// req channel: one word per target (target_x, target_y, elapsed_ms), taken when
// req_valid is high and req_stall is low. rsp channel: one word per request with
// the new heading and the bearing, both in 2^-ANGLE_FRAC_BITS degree units.
// csr port: csr_we writes csr_wdata into center_x (0), center_y (1) or
// max_rate (2); other indexes are dropped.
// order of work after accept: one micro-rotation a cycle, then rounding,
// the step and cap products, the reciprocal divide by 1000 and the commit.
// one word is in flight at a time, so no word is accepted until the last
// has been committed.
// the result sits in an output register; the next word is accepted while it
// waits. if rsp_stall holds, the following word finishes and then waits in
// the controller until the output register frees, with req_stall high.
// reset: heading 0, centre 0,0, max_rate 360, no result pending.
module slew_limited_heading_follower #(
   parameter int ANGLE_FRAC_BITS = 6,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [slhf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [slhf_pkg::COORD_W-1:0]   csr_wdata,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  slhf_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output slhf_pkg::rsp_type              rsp_data
);

   slhf_pkg::cmd_type cmd;
   slhf_pkg::sts_type sts;

   slhf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   slhf_dp #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .CORDIC_STEPS    (CORDIC_STEPS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

FILE: bench/slhf_checker.sv
module slhf_checker (
   input  logic    clock,
   input  logic    reset,
   input  logic    csr_we,
   input  logic [slhf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [slhf_pkg::COORD_W-1:0]   csr_wdata,
   input  logic    req_valid,
   input  logic    req_stall,
   input  slhf_pkg::req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  slhf_pkg::rsp_type rsp_data,
   output int      fail_count,
   output int      pending
);

   localparam int FRAC = 6;
   localparam int STEPS = 16;
   localparam longint UNIT = 1 << FRAC;
   localparam longint TURN = 360 * UNIT;

   logic [slhf_pkg::COORD_W-1:0] pivot_x, pivot_y;
   logic [slhf_pkg::RATE_W-1:0]  rate_limit;
   longint                       heading_now;
   slhf_pkg::rsp_type            heading_queue[$];

   longint arctan_deg16[24] = '{2949120, 1740967, 919879, 466945, 234379, 117305, 58666,
      29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

   function automatic longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint wrap_pos(longint v, longint m);
      longint r;
      r = v % m;
      if (r < 0) r += m;
      return r;
   endfunction

   function automatic longint bearing_of(longint dx, longint dy);
      longint x, y, z, xs, ys, r;
      if (dx == 0 && dy == 0) return 0;
      x = dx * 256;
      y = dy * 256;
      z = 0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = longint'(180) << 16;
      end
      for (int i = 0; i < STEPS; i++) begin
         xs = shr_floor(x, i);
         ys = shr_floor(y, i);
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            z += arctan_deg16[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z -= arctan_deg16[i];
         end
      end
      z = wrap_pos(z, longint'(360) << 16);
      r = (z + (longint'(1) << (16 - FRAC - 1))) >>> (16 - FRAC);
      if (r >= TURN) r -= TURN;
      return r;
   endfunction

   function automatic longint ceil_deg(longint t);
      return ((t + 720 * UNIT + UNIT - 1) >>> FRAC) - 720;
   endfunction

   function automatic slhf_pkg::rsp_type turn_toward(slhf_pkg::req_type w);
      longint a, p, diff, step, cap, delta;
      slhf_pkg::rsp_type o;
      a = bearing_of(longint'(w.target_x) - longint'(pivot_x),
                     longint'(w.target_y) - longint'(pivot_y));
      p = heading_now;
      diff = a - p;
      if (diff < 0) diff = -diff;
      step = diff * w.elapsed_ms / 1000;
      cap = longint'(rate_limit) * UNIT * w.elapsed_ms / 1000;
      delta = step < cap ? step : cap;
      // shorter way round, with the whole-degree ceiling test
      if (a > p) begin
         if (ceil_deg(a - 180 * UNIT) * UNIT > p) p -= delta;
         else p += delta;
      end else if (a < p) begin
         if (ceil_deg(a + 180 * UNIT) * UNIT < p) p += delta;
         else p -= delta;
      end
      heading_now = wrap_pos(p, TURN);
      o.heading = heading_now[slhf_pkg::OUT_W-1:0];
      o.bearing = a[slhf_pkg::OUT_W-1:0];
      return o;
   endfunction

   assign pending = heading_queue.size();

   always @(posedge clock) begin
      slhf_pkg::rsp_type want;
      if (reset) begin
         pivot_x <= '0;
         pivot_y <= '0;
         rate_limit <= slhf_pkg::MAX_RATE_RESET;
         heading_now = 0;
         heading_queue.delete();
         fail_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               slhf_pkg::CSR_CENTER_X: pivot_x <= csr_wdata;
               slhf_pkg::CSR_CENTER_Y: pivot_y <= csr_wdata;
               slhf_pkg::CSR_MAX_RATE: rate_limit <= csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) heading_queue.push_back(turn_toward(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (heading_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected word: heading %0d bearing %0d",
                  rsp_data.heading, rsp_data.bearing);
               fail_count <= fail_count + 1;
            end else begin
               want = heading_queue.pop_front();
               if (want !== rsp_data) begin
                  if (fail_count < 10)
                     $display("mismatch: heading exp %0d got %0d, bearing exp %0d got %0d",
                        want.heading, rsp_data.heading, want.bearing, rsp_data.bearing);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

FILE: bench/tb_slew_limited_heading_follower.sv
module tb_slew_limited_heading_follower;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [slhf_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [slhf_pkg::COORD_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   slhf_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   slhf_pkg::rsp_type rsp_data;
   int fail_count, pending;
   bit stim_done = 1'b0;
   bit hold_off = 1'b0;

   always #5 clock = ~clock;

   slew_limited_heading_follower i_dut (.*);

   slhf_checker i_checker (.*);

   task automatic write_reg(input logic [slhf_pkg::CSR_IDX_W-1:0] idx,
                            input logic [slhf_pkg::COORD_W-1:0] v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // returns at the accepting edge with valid still high; at the following
   // falling edge drain takes it down, the next call only for a gap
   task automatic send_target(input logic [11:0] tx, input logic [11:0] ty,
                              input logic [9:0] ms, input bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 8);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{target_x: tx, target_y: ty, elapsed_ms: ms};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic random_targets(input int n, input int cx, input int cy);
      logic [11:0] tx, ty;
      logic [9:0] ms;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 5))
            0: begin
               // near the pivot, where the bearing moves in big steps
               tx = 12'(cx + $urandom_range(0, 6) - 3);
               ty = 12'(cy + $urandom_range(0, 6) - 3);
            end
            1: begin
               tx = 12'(cx);
               ty = 12'($urandom);
            end
            default: begin
               tx = 12'($urandom);
               ty = 12'($urandom);
            end
         endcase
         case ($urandom_range(0, 3))
            0: ms = 10'($urandom);
            1: ms = 10'($urandom_range(900, 1023));
            default: ms = 10'($urandom_range(0, 60));
         endcase
         send_target(tx, ty, ms, $urandom_range(0, 3) == 0);
      end
   endtask

   // receiver stall: random per word, with one long hold-off
   initial begin
      int gap;
      @(negedge clock);
      while (!stim_done) begin
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (600) @(negedge clock);
            hold_off = 1'b0;
         end
         gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 8);
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(negedge clock);
      end
   end

   initial begin
      #20000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int cx, cy;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed words at reset settings
      send_target(12'd0, 12'd0, 10'd100, 1'b0);
      send_target(12'd4095, 12'd0, 10'd1023, 1'b0);
      send_target(12'd0, 12'd4095, 10'd1023, 1'b0);
      send_target(12'd4095, 12'd4095, 10'd0, 1'b0);
      send_target(12'd100, 12'd0, 10'd500, 1'b0);
      send_target(12'd0, 12'd100, 10'd1000, 1'b0);
      drain();
      write_reg(slhf_pkg::CSR_CENTER_X, 12'd2048);
      write_reg(slhf_pkg::CSR_CENTER_Y, 12'd2048);
      write_reg(slhf_pkg::CSR_MAX_RATE, 12'd4095);
      write_reg(2'd3, 12'd7);
      send_target(12'd2048, 12'd2048, 10'd500, 1'b0);
      send_target(12'd0, 12'd2048, 10'd1023, 1'b0);
      send_target(12'd2048, 12'd0, 10'd1023, 1'b0);
      send_target(12'd4095, 12'd2048, 10'd1023, 1'b0);
      send_target(12'd2048, 12'd4095, 10'd1000, 1'b0);
      send_target(12'd0, 12'd2049, 10'd1023, 1'b0);
      send_target(12'd0, 12'd2047, 10'd1023, 1'b0);
      send_target(12'd2049, 12'd2048, 10'd1, 1'b0);
      send_target(12'd4095, 12'd4095, 10'd0, 1'b0);
      send_target(12'd4095, 12'd0, 10'd700, 1'b0);
      drain();
      write_reg(slhf_pkg::CSR_CENTER_X, 12'd4095);
      write_reg(slhf_pkg::CSR_CENTER_Y, 12'd4095);
      write_reg(slhf_pkg::CSR_MAX_RATE, 12'd0);
      send_target(12'd0, 12'd0, 10'd1023, 1'b0);
      send_target(12'd4095, 12'd4095, 10'd1023, 1'b0);
      drain();

      // back-to-back words while the receiver holds off
      hold_off = 1'b1;
      for (int i = 0; i < 20; i++)
         send_target(12'($urandom), 12'($urandom), 10'($urandom), 1'b1);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         cx = (ph == 0) ? 0 : (ph == 1) ? 4095 : $urandom_range(0, 4095);
         cy = (ph == 0) ? 0 : (ph == 1) ? 4095 : $urandom_range(0, 4095);
         write_reg(slhf_pkg::CSR_CENTER_X, 12'(cx));
         write_reg(slhf_pkg::CSR_CENTER_Y, 12'(cy));
         case (ph)
            0: write_reg(slhf_pkg::CSR_MAX_RATE, 12'd0);
            1: write_reg(slhf_pkg::CSR_MAX_RATE, 12'd4095);
            2: write_reg(slhf_pkg::CSR_MAX_RATE, 12'd360);
            default: write_reg(slhf_pkg::CSR_MAX_RATE, 12'($urandom));
         endcase
         random_targets(210, cx, cy);
         drain();
      end
      stim_done = 1'b1;
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: files.f
hdl/slhf_pkg.sv
hdl/slhf_ctrl.sv
hdl/slhf_dp.sv
hdl/slew_limited_heading_follower.sv
bench/slhf_checker.sv
bench/tb_slew_limited_heading_follower.sv
